>>> rtl/mqs_pkg.sv
// Shared types and constants for the multilevel queue scheduler.
// No dependencies; all other files but mqs_ram refer to it by scoped names.
package mqs_pkg;

  localparam int MAX_TASKS  = 64;
  localparam int ID_W       = $clog2(MAX_TASKS);
  localparam int CNT_W      = ID_W + 1;
  localparam int NUM_LEVELS = 4;
  localparam int LVL_W      = 2;
  localparam int TIME_W     = 32;
  localparam int BURST_W    = 16;
  localparam int QUANT_W    = 8;
  localparam int NUM_QREGS  = 4;
  localparam int QIDX_W     = 2;
  localparam int SLOT_AW    = LVL_W + ID_W;
  localparam int SLOT_DEPTH = NUM_LEVELS * MAX_TASKS;

  localparam logic [1:0] STAT_ACCEPT = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_IDLE   = 2'd2;
  localparam logic [1:0] STAT_RAN    = 2'd3;

  // One task table entry.
  typedef struct packed {
    logic [LVL_W-1:0]   level;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] left;
  } task_t;

  localparam int TASK_W = $bits(task_t);

  // Result of the level scan.
  typedef struct packed {
    logic             preempt;
    logic             any;
    logic [LVL_W-1:0] lvl;
  } pick_t;

endpackage

>>> rtl/mqs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mqs_pick.sv
// Level scan: finds the highest non-empty level and whether the running task
// must yield to a higher one. Depends on mqs_pkg.
module mqs_pick (
  input  logic [mqs_pkg::NUM_LEVELS-1:0][mqs_pkg::CNT_W-1:0] count,
  input  logic                                               run_valid,
  input  logic [mqs_pkg::LVL_W-1:0]                          run_lvl,
  output mqs_pkg::pick_t                                     pick
);

  always_comb begin
    pick = '0;
    // Scan from the lowest priority upward so the highest level wins.
    for (int l = mqs_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
      if (count[l] != '0) begin
        pick.any = 1'b1;
        pick.lvl = mqs_pkg::LVL_W'(l);
        if (run_valid && (mqs_pkg::LVL_W'(l) < run_lvl)) begin
          pick.preempt = 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/multilevel_queue_scheduler_unit.sv
// Top level of the multilevel queue scheduler.
// Depends on mqs_pkg, mqs_ram (task table and queue slots) and mqs_pick.

// Strict-priority multilevel queue scheduler. Each input beat is either an
// arrival (in_tuser = 0) or a one-unit time tick (in_tuser = 1), and each
// produces exactly one result beat. An arrival completes in the cycle it is
// accepted. A tick in which the running task keeps the processor does a task
// table read, then the update; one that dispatches a new task does a queue
// slot read, a task table read and the update; an idle tick completes at
// once. Both memories have registered read ports, read back to back. One
// item is in flight at a time; the result sits in an output register, so the
// next item is taken while that beat is still being drained. Quantum
// registers sit at byte addresses 0, 4, 8 and 12 and should only be written
// while the block is idle; a quantum of zero makes that level first come
// first served.
module multilevel_queue_scheduler_unit (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // task_id[5:0], burst[21:6], level[23:22]
  input  logic [0:0]   in_tuser,   // command[0]
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // ran_task[5:0], first_dispatch[6], finished[7], end_time[39:8],
  // response_time[71:40], turnaround_time[103:72], waiting_time[135:104]
  output logic [135:0] out_tdata,
  output logic [1:0]   out_tuser,  // status[1:0]
  // Configuration port.
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SLOT = 2'd1;
  localparam logic [1:0] S_TASK = 2'd2;

  localparam int ID_W   = mqs_pkg::ID_W;
  localparam int LVL_W  = mqs_pkg::LVL_W;
  localparam int CNT_W  = mqs_pkg::CNT_W;
  localparam int TIME_W = mqs_pkg::TIME_W;
  localparam int NL     = mqs_pkg::NUM_LEVELS;

  // Configuration registers.
  logic [mqs_pkg::QUANT_W-1:0] quant_r [mqs_pkg::NUM_QREGS];
  logic                        cfg_wr;

  // Scheduler state.
  logic [1:0]                  state_r, state_nxt;
  logic [TIME_W-1:0]           time_r, time_nxt;
  logic                        run_valid_r, run_valid_nxt;
  logic [ID_W-1:0]             run_id_r, run_id_nxt;
  logic [LVL_W-1:0]            run_lvl_r, run_lvl_nxt;
  logic [mqs_pkg::QUANT_W-1:0] slice_r, slice_nxt;
  logic                        first_r, first_nxt;
  logic [mqs_pkg::MAX_TASKS-1:0] busy_r, busy_nxt;
  logic [mqs_pkg::MAX_TASKS-1:0] started_r, started_nxt;
  logic [NL-1:0][ID_W-1:0]     head_r, head_nxt;
  logic [NL-1:0][CNT_W-1:0]    count_r, count_nxt;

  // Result register.
  logic                        out_valid_r, out_valid_nxt;
  logic [135:0]                out_data_r, out_data_nxt;
  logic [1:0]                  out_user_r, out_user_nxt;

  // Memory ports.
  logic                        task_we;
  logic [ID_W-1:0]             task_waddr, task_raddr;
  mqs_pkg::task_t              task_wdata, task_rdata;
  logic                        slot_we;
  logic [mqs_pkg::SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [ID_W-1:0]             slot_wdata, slot_rdata;

  mqs_pkg::pick_t              pick;

  // Input fields.
  logic                        in_acc;
  logic                        in_cmd;
  logic [ID_W-1:0]             in_id;
  logic [mqs_pkg::BURST_W-1:0] in_burst;
  logic [LVL_W-1:0]            in_lvl;

  assign in_cmd   = in_tuser[0];
  assign in_id    = in_tdata[5:0];
  assign in_burst = in_tdata[21:6];
  assign in_lvl   = in_tdata[23:22];

  // Take a new item only when idle and the result register is free or draining.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // APB configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {24'd0, quant_r[cfg_paddr[3:2]]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mqs_pkg::NUM_QREGS; i++) begin
        quant_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      quant_r[cfg_paddr[3:2]] <= cfg_pwdata[mqs_pkg::QUANT_W-1:0];
    end
  end

  mqs_ram #(.WIDTH(mqs_pkg::TASK_W), .DEPTH(mqs_pkg::MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_wdata),
    .raddr (task_raddr),
    .rdata (task_rdata)
  );

  mqs_ram #(.WIDTH(ID_W), .DEPTH(mqs_pkg::SLOT_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  mqs_pick u_pick (
    .count     (count_r),
    .run_valid (run_valid_r),
    .run_lvl   (run_lvl_r),
    .pick      (pick)
  );

  always_comb begin
    logic [TIME_W-1:0]           time_inc;
    logic [mqs_pkg::BURST_W-1:0] left_n;
    logic                        done;
    logic [TIME_W-1:0]           resp, tat, wait_t;
    logic [mqs_pkg::QUANT_W-1:0] quant, slice_inc;
    logic                        requeue;

    state_nxt     = state_r;
    time_nxt      = time_r;
    run_valid_nxt = run_valid_r;
    run_id_nxt    = run_id_r;
    run_lvl_nxt   = run_lvl_r;
    slice_nxt     = slice_r;
    first_nxt     = first_r;
    busy_nxt      = busy_r;
    started_nxt   = started_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    task_we    = 1'b0;
    task_waddr = run_id_r;
    task_wdata = task_rdata;
    task_raddr = run_id_r;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = run_id_r;
    slot_raddr = '0;

    // The counter saturates at its maximum.
    time_inc  = (time_r == '1) ? time_r : time_r + 1'b1;
    left_n    = '0;
    done      = 1'b0;
    resp      = '0;
    tat       = '0;
    wait_t    = '0;
    quant     = '0;
    slice_inc = '0;
    requeue   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc && !in_cmd) begin
          // Arrival: the result is registered in the same cycle.
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[39:8] = time_r;
          if (in_burst == '0 || busy_r[in_id]) begin
            out_user_nxt = mqs_pkg::STAT_REJECT;
          end else begin
            out_user_nxt        = mqs_pkg::STAT_ACCEPT;
            busy_nxt[in_id]     = 1'b1;
            started_nxt[in_id]  = 1'b0;
            task_we             = 1'b1;
            task_waddr          = in_id;
            task_wdata.level    = in_lvl;
            task_wdata.arrival  = time_r;
            task_wdata.burst    = in_burst;
            task_wdata.left     = in_burst;
            if (count_r[in_lvl] < CNT_W'(mqs_pkg::MAX_TASKS)) begin
              slot_we    = 1'b1;
              slot_waddr = {in_lvl, head_r[in_lvl] + count_r[in_lvl][ID_W-1:0]};
              slot_wdata = in_id;
              count_nxt[in_lvl] = count_r[in_lvl] + 1'b1;
            end
          end
        end else if (in_acc) begin
          // Tick. A higher level with waiting work sends the running task
          // back to the front of its own queue.
          if (pick.preempt) begin
            if (count_r[run_lvl_r] < CNT_W'(mqs_pkg::MAX_TASKS)) begin
              head_nxt[run_lvl_r]  = head_r[run_lvl_r] - 1'b1;
              slot_we              = 1'b1;
              slot_waddr           = {run_lvl_r, head_r[run_lvl_r] - 1'b1};
              slot_wdata           = run_id_r;
              count_nxt[run_lvl_r] = count_r[run_lvl_r] + 1'b1;
            end
            run_valid_nxt = 1'b0;
            slice_nxt     = '0;
          end
          if (run_valid_r && !pick.preempt) begin
            task_raddr = run_id_r;
            first_nxt  = 1'b0;
            state_nxt  = S_TASK;
          end else if (pick.any) begin
            // Pop the head of the highest non-empty level. The preempted
            // level, if any, is lower, so the two updates never collide.
            slot_raddr           = {pick.lvl, head_r[pick.lvl]};
            head_nxt[pick.lvl]   = head_r[pick.lvl] + 1'b1;
            count_nxt[pick.lvl]  = count_r[pick.lvl] - 1'b1;
            run_lvl_nxt          = pick.lvl;
            slice_nxt            = '0;
            state_nxt            = S_SLOT;
          end else begin
            time_nxt           = time_inc;
            out_valid_nxt      = 1'b1;
            out_user_nxt       = mqs_pkg::STAT_IDLE;
            out_data_nxt       = '0;
            out_data_nxt[39:8] = time_inc;
          end
        end
      end

      S_SLOT: begin
        // The dispatched id is back from the queue memory.
        run_id_nxt    = slot_rdata;
        run_valid_nxt = 1'b1;
        task_raddr    = slot_rdata;
        first_nxt     = !started_r[slot_rdata];
        started_nxt[slot_rdata] = 1'b1;
        state_nxt     = S_TASK;
      end

      S_TASK: begin
        // Run one unit and write the entry back.
        left_n = (task_rdata.left != '0) ? task_rdata.left - 1'b1 : '0;
        done   = (left_n == '0);
        resp   = first_r ? time_r - task_rdata.arrival : '0;
        task_we         = 1'b1;
        task_waddr      = run_id_r;
        task_wdata      = task_rdata;
        task_wdata.left = left_n;
        time_nxt        = time_inc;
        if (done) begin
          tat    = time_inc - task_rdata.arrival;
          wait_t = (tat > TIME_W'(task_rdata.burst)) ?
                   tat - TIME_W'(task_rdata.burst) : '0;
          busy_nxt[run_id_r] = 1'b0;
          run_valid_nxt      = 1'b0;
          slice_nxt          = '0;
        end else begin
          quant     = quant_r[run_lvl_r];
          slice_inc = slice_r + 1'b1;
          if (quant != '0) begin
            slice_nxt = slice_inc;
            requeue   = (slice_inc == quant);
          end
          if (requeue) begin
            // Slice expired: back of its own queue.
            if (count_r[run_lvl_r] < CNT_W'(mqs_pkg::MAX_TASKS)) begin
              slot_we    = 1'b1;
              slot_waddr = {run_lvl_r,
                            head_r[run_lvl_r] + count_r[run_lvl_r][ID_W-1:0]};
              slot_wdata = run_id_r;
              count_nxt[run_lvl_r] = count_r[run_lvl_r] + 1'b1;
            end
            run_valid_nxt = 1'b0;
            slice_nxt     = '0;
          end
        end
        out_valid_nxt          = 1'b1;
        out_user_nxt           = mqs_pkg::STAT_RAN;
        out_data_nxt[5:0]      = run_id_r;
        out_data_nxt[6]        = first_r;
        out_data_nxt[7]        = done;
        out_data_nxt[39:8]     = time_inc;
        out_data_nxt[71:40]    = resp;
        out_data_nxt[103:72]   = tat;
        out_data_nxt[135:104]  = wait_t;
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      run_lvl_r   <= '0;
      slice_r     <= '0;
      first_r     <= 1'b0;
      busy_r      <= '0;
      started_r   <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
      run_lvl_r   <= run_lvl_nxt;
      slice_r     <= slice_nxt;
      first_r     <= first_nxt;
      busy_r      <= busy_nxt;
      started_r   <= started_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

`ifndef SYNTHESIS
  // A new item is only taken between ticks.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE))
    else $error("input taken while a tick is in progress");

  // An accepted arrival marks its id busy.
  a_arrive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_cmd && in_burst != '0 && !busy_r[in_id])
      |=> busy_r[$past(in_id)])
    else $error("accepted arrival did not mark its id busy");

  // Queue occupancy never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= CNT_W'(mqs_pkg::MAX_TASKS)) &&
    (count_r[1] <= CNT_W'(mqs_pkg::MAX_TASKS)) &&
    (count_r[2] <= CNT_W'(mqs_pkg::MAX_TASKS)) &&
    (count_r[3] <= CNT_W'(mqs_pkg::MAX_TASKS)))
    else $error("queue count overflow");
`endif

endmodule

>>> verif/multilevel_queue_scheduler_unit_test.sv
// Self-checking testbench for multilevel_queue_scheduler_unit.
// It depends on mqs_pkg and the RTL. It predicts every result beat with a
// behavioral scheduler model and checks each beat as it arrives.
module multilevel_queue_scheduler_unit_test;

  localparam int   MAX_TASKS  = mqs_pkg::MAX_TASKS;
  localparam int   NUM_LEVELS = mqs_pkg::NUM_LEVELS;
  localparam int   NUM_QREGS  = mqs_pkg::NUM_QREGS;
  localparam int   ID_W       = mqs_pkg::ID_W;
  localparam int   LVL_W      = mqs_pkg::LVL_W;
  localparam int   BURST_W    = mqs_pkg::BURST_W;
  localparam int   TIME_W     = mqs_pkg::TIME_W;
  localparam int   QUANT_W    = mqs_pkg::QUANT_W;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;
  localparam int   STALL_LIMIT = 4000;
  localparam int   RANDOM_PER_PHASE = 300;

  typedef struct packed {
    logic               cmd;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [LVL_W-1:0]   lvl;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   ran;
    logic              first;
    logic              fin;
    logic [TIME_W-1:0] end_t;
    logic [TIME_W-1:0] resp;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wait_t;
  } sched_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [23:0]  in_tdata;   // task_id[5:0], burst[21:6], level[23:22]
  logic [0:0]   in_tuser;   // command[0]
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // ran_task, first, finished, end, response, turnaround, waiting
  logic [1:0]   out_tuser;  // status[1:0]
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  multilevel_queue_scheduler_unit uut (.*);

  // Stimulus waiting to be driven, and results the scheduler owes us.
  sched_cmd_t pending_cmds[$];
  sched_res_t owed_results[$];

  // Shadow copy of the scheduler: task table, ready queues, time and quanta.
  logic [QUANT_W-1:0] shadow_quantum [NUM_QREGS];
  logic [TIME_W-1:0]  clock_now;
  logic               cpu_busy;
  logic [ID_W-1:0]    cpu_task;
  logic [QUANT_W-1:0] slice_count;
  logic               busy_tbl    [MAX_TASKS];
  logic               started_tbl [MAX_TASKS];
  logic [BURST_W-1:0] left_tbl    [MAX_TASKS];
  logic [BURST_W-1:0] burst_tbl   [MAX_TASKS];
  logic [TIME_W-1:0]  arrival_tbl [MAX_TASKS];
  logic [LVL_W-1:0]   level_tbl   [MAX_TASKS];
  logic [ID_W-1:0]    ready_slots [NUM_LEVELS][MAX_TASKS];
  logic [ID_W-1:0]    ready_head  [NUM_LEVELS];
  int                 ready_cnt   [NUM_LEVELS];

  int  fail_count;
  int  beats_in;
  int  beats_out;
  int  finish_count;
  int  preempt_count;
  int  stall_cycles;
  typedef enum logic { GAPS_ON, GAPS_OFF } bool_gaps_t;
  bool_gaps_t gap_mode;
  bit  in_taken;
  int  in_gap;
  int  out_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short idles, now and then a long one; none at all in quiet phases.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (gap_mode == GAPS_OFF || r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [TIME_W-1:0] time_inc(input logic [TIME_W-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  // The scheduler's response to one accepted command, appended to owed_results.
  task automatic schedule_step(input sched_cmd_t c);
    sched_res_t r;
    int         l;
    int         top;
    logic [LVL_W-1:0] cur;
    logic [QUANT_W-1:0] q;
    r = '0;
    if (c.cmd == CMD_ARRIVE) begin
      if (c.burst == 0 || busy_tbl[c.id]) begin
        r.status = mqs_pkg::STAT_REJECT;
      end else begin
        busy_tbl[c.id]    = 1'b1;
        started_tbl[c.id] = 1'b0;
        left_tbl[c.id]    = c.burst;
        burst_tbl[c.id]   = c.burst;
        arrival_tbl[c.id] = clock_now;
        level_tbl[c.id]   = c.lvl;
        ready_slots[c.lvl][(ready_head[c.lvl] + ready_cnt[c.lvl]) % MAX_TASKS] = c.id;
        ready_cnt[c.lvl]++;
        r.status = mqs_pkg::STAT_ACCEPT;
      end
      r.end_t = clock_now;
      owed_results.insert(owed_results.size(), r);
      return;
    end

    // A waiting task on a higher level pushes the running one back to the
    // front of its own queue.
    if (cpu_busy) begin
      cur = level_tbl[cpu_task];
      for (l = 0; l < cur; l++) begin
        if (ready_cnt[l] != 0 && cpu_busy) begin
          ready_head[cur] = ready_head[cur] - 1'b1;
          ready_slots[cur][ready_head[cur]] = cpu_task;
          ready_cnt[cur]++;
          cpu_busy = 1'b0;
          slice_count = '0;
          preempt_count++;
        end
      end
    end

    if (!cpu_busy) begin
      top = NUM_LEVELS;
      for (l = NUM_LEVELS - 1; l >= 0; l--) if (ready_cnt[l] != 0) top = l;
      if (top == NUM_LEVELS) begin
        clock_now = time_inc(clock_now);
        r.status = mqs_pkg::STAT_IDLE;
        r.end_t  = clock_now;
        owed_results.insert(owed_results.size(), r);
        return;
      end
      cpu_task = ready_slots[top][ready_head[top]];
      ready_head[top] = ready_head[top] + 1'b1;
      ready_cnt[top]--;
      cpu_busy = 1'b1;
      slice_count = '0;
      if (!started_tbl[cpu_task]) begin
        started_tbl[cpu_task] = 1'b1;
        r.first = 1'b1;
        r.resp  = clock_now - arrival_tbl[cpu_task];
      end
    end

    if (left_tbl[cpu_task] != 0) left_tbl[cpu_task]--;
    clock_now = time_inc(clock_now);
    if (left_tbl[cpu_task] == 0) begin
      r.fin    = 1'b1;
      r.tat    = clock_now - arrival_tbl[cpu_task];
      r.wait_t = (r.tat > burst_tbl[cpu_task]) ? r.tat - burst_tbl[cpu_task] : '0;
      busy_tbl[cpu_task] = 1'b0;
      cpu_busy = 1'b0;
      slice_count = '0;
      finish_count++;
    end else begin
      cur = level_tbl[cpu_task];
      q = shadow_quantum[cur];
      if (q != 0) begin
        slice_count = slice_count + 1'b1;
        if (slice_count == q) begin
          // Slice used up: round robin sends the task to the back.
          ready_slots[cur][(ready_head[cur] + ready_cnt[cur]) % MAX_TASKS] = cpu_task;
          ready_cnt[cur]++;
          cpu_busy = 1'b0;
          slice_count = '0;
        end
      end
    end
    r.status = mqs_pkg::STAT_RAN;
    r.ran    = cpu_task;
    r.end_t  = clock_now;
    owed_results.insert(owed_results.size(), r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor and predictor: both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    sched_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        schedule_step(sched_cmd_t'{in_tuser[0], in_tdata[5:0], in_tdata[21:6],
                                   in_tdata[23:22]});
        in_taken = 1'b1;
        beats_in++;
      end
      if (out_tvalid && out_tready) begin
        beats_out++;
        if (owed_results.size() == 0) begin
          $error("result beat with no outstanding command, status %0d", out_tuser);
          fail_count++;
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          check_field("status", want.status, out_tuser);
          check_field("ran_task", want.ran, out_tdata[5:0]);
          check_field("first_dispatch", want.first, out_tdata[6]);
          check_field("finished", want.fin, out_tdata[7]);
          check_field("end_time", want.end_t, out_tdata[39:8]);
          check_field("response_time", want.resp, out_tdata[71:40]);
          check_field("turnaround_time", want.tat, out_tdata[103:72]);
          check_field("waiting_time", want.wait_t, out_tdata[135:104]);
        end
      end
      // Watchdog: too long without any beat moving means the block hung.
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("multilevel_queue_scheduler_unit_test: FAIL");
          $finish;
        end
      end
    end
  end

  // Command driver: holds a beat until it is taken, then idles or loads the next.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0 || pending_cmds.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_tvalid <= 1'b0;
      end else begin
        sched_cmd_t c;
        c = pending_cmds[0];
        pending_cmds.delete(0);
        in_tdata  <= {c.lvl, c.burst, c.id};
        in_tuser  <= c.cmd;
        in_tvalid <= 1'b1;
        in_gap = idle_len();
      end
    end
  end

  // Result sink: random back-pressure.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = idle_len();
    end
  end

  task automatic cfg_write(input int idx, input logic [7:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(4 * idx);
    cfg_pwdata  <= {24'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shadow_quantum[idx] = val;
  endtask

  task automatic push_cmd(input logic cmd, input int id, input int burst, input int lvl);
    pending_cmds.insert(pending_cmds.size(),
                        sched_cmd_t'{cmd, ID_W'(id), BURST_W'(burst), LVL_W'(lvl)});
  endtask

  // Random traffic: roughly a quarter arrivals with short bursts, the rest ticks.
  task automatic add_random_cmds(input int n);
    int i;
    int r;
    int b;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 28) begin
        r = $urandom_range(99);
        if (r < 3)       b = 0;
        else if (r < 88) b = $urandom_range(4, 1);
        else             b = $urandom_range(40, 5);
        push_cmd(CMD_ARRIVE, $urandom_range(63), b, $urandom_range(3));
      end else begin
        push_cmd(CMD_TICK, $urandom_range(63), $urandom_range(65535), $urandom_range(3));
      end
    end
  endtask

  // Block until every queued command has gone in and every result has come out.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_tvalid || owed_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int p;
    int k;
    fail_count = 0; beats_in = 0; beats_out = 0; finish_count = 0;
    preempt_count = 0; stall_cycles = 0; in_taken = 1'b0;
    in_gap = 0; out_gap = 0; gap_mode = GAPS_ON;
    clock_now = '0; cpu_busy = 1'b0; cpu_task = '0; slice_count = '0;
    for (k = 0; k < MAX_TASKS; k++) begin
      busy_tbl[k] = 1'b0;
      started_tbl[k] = 1'b0;
    end
    for (k = 0; k < NUM_LEVELS; k++) begin
      ready_head[k] = '0;
      ready_cnt[k] = 0;
    end
    for (k = 0; k < NUM_QREGS; k++) shadow_quantum[k] = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: a mix of round robin and first come first served.
    cfg_write(0, 8'd0);
    cfg_write(1, 8'd2);
    cfg_write(2, 8'd1);
    cfg_write(3, 8'd0);
    push_cmd(CMD_TICK, 0, 0, 0);              // idle tick on an empty scheduler
    push_cmd(CMD_ARRIVE, 0, 0, 0);            // zero burst is refused
    push_cmd(CMD_ARRIVE, 63, 65535, 3);       // widest burst, last id, lowest level
    push_cmd(CMD_ARRIVE, 63, 1, 0);           // same id again while busy
    push_cmd(CMD_ARRIVE, 21, 3, 2);
    push_cmd(CMD_ARRIVE, 42, 2, 2);
    push_cmd(CMD_TICK, 63, 65535, 3);
    push_cmd(CMD_TICK, 0, 0, 0);              // level 2 slice of one: rotation
    push_cmd(CMD_ARRIVE, 1, 5, 1);
    push_cmd(CMD_TICK, 0, 0, 0);              // level 1 is picked ahead of level 2
    push_cmd(CMD_ARRIVE, 0, 1, 0);
    push_cmd(CMD_TICK, 0, 0, 0);              // level 0 preempts level 1
    for (k = 0; k < 12; k++) push_cmd(CMD_TICK, 0, 0, 0);
    drain();

    // Random phases over several quantum settings, the extremes among them.
    for (p = 0; p < 5; p++) begin
      gap_mode = (p == 2) ? GAPS_OFF : GAPS_ON;
      for (k = 0; k < NUM_QREGS; k++) begin
        case (p)
          0: cfg_write(k, 8'd0);
          1: cfg_write(k, 8'd1);
          2: cfg_write(k, 8'd255);
          3: cfg_write(k, 8'($urandom_range(4)));
          default: cfg_write(k, 8'($urandom_range(255)));
        endcase
      end
      add_random_cmds(RANDOM_PER_PHASE);
      drain();
    end

    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      fail_count++;
    end
    $display("Ran %0d command beats and checked %0d result beats over six quantum setups.",
             beats_in, beats_out);
    $display("Tasks finished: %0d, preemptions seen by the model: %0d.",
             finish_count, preempt_count);
    if (fail_count == 0) begin
      $display("multilevel_queue_scheduler_unit_test: PASS");
    end else begin
      $display("multilevel_queue_scheduler_unit_test: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mqs_pkg.sv
rtl/mqs_ram.sv
rtl/mqs_pick.sv
rtl/multilevel_queue_scheduler_unit.sv
verif/multilevel_queue_scheduler_unit_test.sv
